// ----- hw/rtl/cfr_pkg.sv -----
package cfr_pkg;

  // op codes of an input beat
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_PIN    = 3'd2,
    OP_UNPIN  = 3'd3,
    OP_MARK   = 3'd4,
    OP_PICK   = 3'd5
  } cfr_op_e;

  // status codes of a result beat
  typedef enum logic [1:0] {
    STATUS_DONE        = 2'd0,
    STATUS_NO_VICTIM   = 2'd1,
    STATUS_PIN_REFUSED = 2'd2
  } cfr_status_e;

  localparam int unsigned FrameIdxW = 6;
  localparam int unsigned MarkW     = 3;

  typedef struct packed {
    logic [2:0]           op;
    logic [FrameIdxW-1:0] frame_index;
  } cfr_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [FrameIdxW-1:0] victim_index;
  } cfr_rsp_t;

  // per-frame marks as stored in the table memory
  typedef struct packed {
    logic valid;
    logic pinned;
    logic accessed;
  } cfr_marks_t;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SCAN  = 4'b1000
  } cfr_state_e;

endpackage

// ----- hw/rtl/cfr_ram.sv -----
module cfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/cfr_engine.sv -----
module cfr_engine import cfr_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 64,
  localparam int unsigned AddrW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  cfr_req_t         req_i,
  output logic             rsp_valid_o,
  output cfr_rsp_t         rsp_o,
  input  logic             rsp_free_i,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  logic [MarkW-1:0] mem_rdata_i,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [MarkW-1:0] mem_wdata_o
);

  localparam int unsigned CntW = AddrW + 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(NUM_FRAMES - 1);
  localparam logic [CntW-1:0]  LastCnt = CntW'(2 * NUM_FRAMES - 1);

  cfr_state_e       state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] cursor_q, cursor_d;
  logic [2:0]       op_q;
  logic [AddrW-1:0] idx_q;
  logic             exists_q;

  cfr_marks_t       rd_marks;
  cfr_marks_t       wr_marks;
  logic             hit;
  logic             accept;
  logic [AddrW-1:0] cursor_next;
  logic [AddrW-1:0] addr_next;

  function automatic logic [AddrW-1:0] next_slot(input logic [AddrW-1:0] a);
    next_slot = (a == LastIdx) ? '0 : a + AddrW'(1);
  endfunction

  assign rd_marks    = cfr_marks_t'(mem_rdata_i);
  assign hit         = exists_q && rd_marks.valid;
  assign accept      = req_valid_i && req_ready_o;
  assign cursor_next = next_slot(cursor_q);
  assign addr_next   = next_slot(addr_q);
  assign mem_wdata_o = wr_marks;

  // sequencer: clearing pass, single updates, victim sweep
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    cursor_d    = cursor_q;
    req_ready_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = AddrW'(req_i.frame_index);
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    wr_marks    = rd_marks;
    rsp_valid_o = 1'b0;
    rsp_o       = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr_q;
        wr_marks    = '0;
        if (addr_q == LastIdx) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end

      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          mem_re_o = 1'b1;
          if (req_i.op == OP_PICK) begin
            mem_raddr_o = cursor_next;
            addr_d      = cursor_next;
            cnt_d       = '0;
            state_d     = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (rsp_free_i) begin
          rsp_valid_o = 1'b1;
          state_d     = S_IDLE;
          case (op_q)
            OP_ADD: begin
              mem_we_o = exists_q;
              wr_marks = '{valid: 1'b1, pinned: 1'b1, accessed: 1'b0};
            end
            OP_REMOVE: begin
              mem_we_o = hit;
              wr_marks = '0;
              if (hit && (cursor_q == idx_q)) begin
                cursor_d = cursor_next;
              end
            end
            OP_PIN: begin
              if (!hit || rd_marks.pinned) begin
                rsp_o.status = STATUS_PIN_REFUSED;
              end else begin
                mem_we_o        = 1'b1;
                wr_marks.pinned = 1'b1;
              end
            end
            OP_UNPIN: begin
              mem_we_o        = hit;
              wr_marks.pinned = 1'b0;
            end
            OP_MARK: begin
              mem_we_o          = hit;
              wr_marks.accessed = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        mem_waddr_o = addr_q;
        if (rd_marks.valid && !rd_marks.pinned && !rd_marks.accessed) begin
          // victim found: pin it and park the cursor on it
          if (rsp_free_i) begin
            mem_we_o           = 1'b1;
            wr_marks.pinned    = 1'b1;
            cursor_d           = addr_q;
            rsp_valid_o        = 1'b1;
            rsp_o.victim_index = FrameIdxW'(addr_q);
            state_d            = S_IDLE;
          end
        end else if (cnt_q == LastCnt) begin
          // two full sweeps without a victim
          if (rsp_free_i) begin
            mem_we_o          = rd_marks.valid;
            wr_marks.accessed = 1'b0;
            rsp_valid_o       = 1'b1;
            rsp_o.status      = STATUS_NO_VICTIM;
            state_d           = S_IDLE;
          end
        end else begin
          // second chance: clear accessed and move on
          mem_we_o          = rd_marks.valid;
          wr_marks.accessed = 1'b0;
          cnt_d             = cnt_q + CntW'(1);
          mem_re_o          = 1'b1;
          mem_raddr_o       = addr_next;
          addr_d            = addr_next;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      addr_q   <= '0;
      cnt_q    <= '0;
      cursor_q <= LastIdx;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      cnt_q    <= cnt_d;
      cursor_q <= cursor_d;
    end
  end

  // captured request fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.op;
      idx_q    <= AddrW'(req_i.frame_index);
      exists_q <= (32'(req_i.frame_index) < NUM_FRAMES);
    end
  end

endmodule

// ----- hw/rtl/clock_frame_replacement.sv -----
// channel | direction | handshake                  | payload
// in      | input     | in_valid_i / in_ready_o    | in_data_i  (op, frame_index)
// out     | output    | out_valid_o / out_ready_i  | out_data_o (status, victim_index)
//
// add, remove, pin, unpin, mark and unused ops go through a table read, then the
// write-back with the result loaded into the output register.
// a victim pick examines 1 to 2*NUM_FRAMES entries, one entry per cycle through the
// single table read port; only the last entry waits for the output register to be free.
// after reset all NUM_FRAMES table entries are swept to zero before in_ready_o rises.
// a result waiting in the output register does not block acceptance of the next beat;
// the controller waits only when it has a new result and the register is still full.
module clock_frame_replacement import cfr_pkg::*; #(
  parameter int unsigned NUM_FRAMES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  cfr_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cfr_rsp_t out_data_o
);

  localparam int unsigned AddrW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  logic             rsp_valid;
  cfr_rsp_t         rsp;
  logic             rsp_free;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [MarkW-1:0] mem_rdata;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [MarkW-1:0] mem_wdata;

  logic             out_valid_q;
  cfr_rsp_t         out_q;

  // frame marks table
  cfr_ram #(
    .WIDTH (MarkW),
    .DEPTH (NUM_FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cfr_engine #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .rsp_free_i  (rsp_free),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  // output register
  assign rsp_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/cfr_checker.sv -----
module cfr_checker import cfr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input cfr_req_t in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input cfr_rsp_t out_data_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // one item at a time: ready drops after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("beat accepted while previous item in flight");

  // a failed result (no victim, pin refused) carries a zero victim index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_DONE) |-> out_data_o.victim_index == '0)
    else $error("victim index set on a failed result");

  // status never takes the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_DONE) ||
                    (out_data_o.status == STATUS_NO_VICTIM) ||
                    (out_data_o.status == STATUS_PIN_REFUSED))
    else $error("unused status code");

endmodule

bind clock_frame_replacement cfr_checker u_cfr_checker (.*);
